>>> hw/rtl/psp_pkg.sv
package psp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAV_X  = 3'd0,
		CFG_GRAV_Y  = 3'd1,
		CFG_GRAV_Z  = 3'd2,
		CFG_WIND_X  = 3'd3,
		CFG_WIND_Y  = 3'd4,
		CFG_WIND_Z  = 3'd5,
		CFG_DENSITY = 3'd6
	} cfg_idx_t;

	localparam logic [31:0] GRAV_X_RST  = 32'd0;
	localparam logic [31:0] GRAV_Y_RST  = 32'hFFF6_30A4;	// about -9.81
	localparam logic [31:0] GRAV_Z_RST  = 32'd0;
	localparam logic [31:0] WIND_RST    = 32'd0;
	localparam logic [30:0] DENSITY_RST = 31'd80282;	// about 1.225
	localparam logic [30:0] ONE_Q16     = 31'd65536;

	// iterative stage counts
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 62;
	localparam int DIV_LOW_W   = 46;	// k3 bits below the initial remainder
	localparam int DIV_SHIFT   = 16;	// dividend is k3 scaled by 2^16

	localparam logic [62:0] DRAG_CAP = 63'h4000_0000_0000_0000;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [19:0]        step_time;
		logic [30:0]        body_mass;
		logic [30:0]        drag_coeff;
		logic [30:0]        cross_area;
	} body_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
	} pred_t;

	// lane 0 is x
	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		vec3_t       pos;
		vec3_t       vel;
		logic [19:0] dt;
		logic [23:0] dt2;
		logic [30:0] mass;
		logic [60:0] k2;
	} sq_side_t;

	typedef struct packed {
		vec3_t       pos;
		vec3_t       vel;
		logic [19:0] dt;
		logic [23:0] dt2;
	} dv_side_t;

	function automatic logic [31:0] sat_s32_64(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647) r = 32'h7FFF_FFFF;
		else if (x < -64'sd2147483648) r = 32'h8000_0000;
		else r = x[31:0];
		return r;
	endfunction

	function automatic logic [31:0] sat_s32_42(input logic signed [41:0] x);
		logic [31:0] r;
		if (x > 42'sd2147483647) r = 32'h7FFF_FFFF;
		else if (x < -42'sd2147483648) r = 32'h8000_0000;
		else r = x[31:0];
		return r;
	endfunction

endpackage

>>> hw/rtl/psp_isqrt_pipe.sv
module psp_isqrt_pipe import psp_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [31:0]       root,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [SQRT_STAGES+1];
	logic [63:0]       rem_s  [SQRT_STAGES+1];
	logic [31:0]       root_s [SQRT_STAGES+1];
	logic [SIDE_W-1:0] side_s [SQRT_STAGES+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	// one result bit per stage, msb first; rem holds n - root^2
	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_step
		localparam int B = SQRT_STAGES - 1 - g;
		logic [63:0] trial;
		logic        fits;

		assign trial = ({32'b0, root_s[g]} << (B + 1)) | (64'd1 << (2 * B));
		assign fits  = rem_s[g] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= fits ? rem_s[g] - trial : rem_s[g];
				root_s[g+1] <= fits ? (root_s[g] | (32'd1 << B)) : root_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = vld_s[SQRT_STAGES];
	assign root      = root_s[SQRT_STAGES];
	assign out_side  = side_s[SQRT_STAGES];

	a_sqrt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SQRT_STAGES] |-> rem_s[SQRT_STAGES] <= {31'b0, root_s[SQRT_STAGES], 1'b0})
		else $error("root remainder above 2*root");

endmodule

>>> hw/rtl/psp_div_pipe.sv
module psp_div_pipe import psp_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [62:0]       k3,
	input  logic [30:0]       mass,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [62:0]       k4,
	output logic [SIDE_W-1:0] out_side
);

	logic                 vld_s  [DIV_STAGES+1];
	logic                 sat_s  [DIV_STAGES+1];
	logic [30:0]          rem_s  [DIV_STAGES+1];
	logic [DIV_STAGES-1:0] q_s   [DIV_STAGES+1];
	logic [DIV_LOW_W-1:0] low_s  [DIV_STAGES+1];
	logic [30:0]          mass_s [DIV_STAGES+1];
	logic [SIDE_W-1:0]    side_s [DIV_STAGES+1];

	// quotient saturates when k3*2^16 >= mass*2^62, i.e. k3>>46 >= mass
	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = {14'b0, k3[62:DIV_LOW_W]};
	assign sat_s[0]  = {14'b0, k3[62:DIV_LOW_W]} >= mass;
	assign q_s[0]    = '0;
	assign low_s[0]  = k3[DIV_LOW_W-1:0];
	assign mass_s[0] = mass;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
		localparam int B = DIV_STAGES - 1 - g;
		logic        nbit;
		logic [31:0] wide;
		logic        ge;

		if (B >= DIV_SHIFT) begin : g_data
			assign nbit = low_s[g][B-DIV_SHIFT];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		assign wide = {rem_s[g], nbit};
		assign ge   = wide >= {1'b0, mass_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= ge ? 31'(wide - {1'b0, mass_s[g]}) : wide[30:0];
				q_s[g+1]    <= ge ? (q_s[g] | (DIV_STAGES'(1) << B)) : q_s[g];
				sat_s[g+1]  <= sat_s[g];
				low_s[g+1]  <= low_s[g];
				mass_s[g+1] <= mass_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign k4        = sat_s[DIV_STAGES] ? DRAG_CAP : {1'b0, q_s[DIV_STAGES]};
	assign out_side  = side_s[DIV_STAGES];

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STAGES] && !sat_s[DIV_STAGES] |-> rem_s[DIV_STAGES] < mass_s[DIV_STAGES])
		else $error("division remainder not below divisor");

endmodule

>>> hw/rtl/projectile_state_predict_drag.sv
// Projectile step with quadratic drag, one body per word.
// body channel: body_valid / body_stall / body carry position and velocity (signed Q16.16),
// time step, mass, drag coefficient and cross section (unsigned, 16 fraction bits).
// pred channel: pred_valid / pred_stall / pred return the new position
// and velocity, saturated to signed Q16.16, one word per body, in order.
// cfg_we / cfg_index / cfg_data write gravity, wind and air density;
// write only while no body is in flight.
// Throughput: one word per cycle while body_stall is low. The pipeline has
// 104 register stages, most of them in the 32-stage square root (one root
// bit a stage) and the 62-stage divide by mass (one quotient bit a stage).
// Reset empties the pipeline and loads gravity (0, -9.81, 0), zero wind
// and density 1.225.
// When pred_stall holds a word, the next one lands in a skid register and
// body_stall rises as the skid register fills; nothing is dropped or repeated.
module projectile_state_predict_drag import psp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  body_valid,
	output logic                  body_stall,
	input  body_t                 body,
	output logic                  pred_valid,
	input  logic                  pred_stall,
	output pred_t                 pred,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [31:0] grav_q [3];
	logic [31:0] wind_q [3];
	logic [30:0] density_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q[0] <= GRAV_X_RST;
			grav_q[1] <= GRAV_Y_RST;
			grav_q[2] <= GRAV_Z_RST;
			wind_q[0] <= WIND_RST;
			wind_q[1] <= WIND_RST;
			wind_q[2] <= WIND_RST;
			density_q <= DENSITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRAV_X:  grav_q[0] <= cfg_data;
				CFG_GRAV_Y:  grav_q[1] <= cfg_data;
				CFG_GRAV_Z:  grav_q[2] <= cfg_data;
				CFG_WIND_X:  wind_q[0] <= cfg_data;
				CFG_WIND_Y:  wind_q[1] <= cfg_data;
				CFG_WIND_Z:  wind_q[2] <= cfg_data;
				CFG_DENSITY: density_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q, skid_valid_q;
	pred_t out_q, skid_q;

	assign en         = !skid_valid_q;
	assign body_stall = skid_valid_q;

	// ---- stage 1: magnitudes, rho*Cd
	vec3_t       vel_in, mag_c;
	logic [61:0] rhocd_c;
	logic [30:0] mass_c;

	logic        vld_s1;
	vec3_t       pos_s1, vel_s1, mag_s1;
	logic [19:0] dt_s1;
	logic [30:0] mass_s1, area_s1;
	logic [61:0] rhocd_s1;

	assign vel_in = {body.vel_z, body.vel_y, body.vel_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vel_in[i][31] ? (~vel_in[i] + 32'd1) : vel_in[i];
		end
		rhocd_c = density_q * body.drag_coeff;
		mass_c  = (body.body_mass == '0) ? ONE_Q16 : body.body_mass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= body_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1   <= {body.pos_z, body.pos_y, body.pos_x};
			vel_s1   <= vel_in;
			mag_s1   <= mag_c;
			dt_s1    <= body.step_time;
			mass_s1  <= mass_c;
			area_s1  <= body.cross_area;
			rhocd_s1 <= rhocd_c;
		end
	end

	// ---- stage 2: squares, dt^2, k1*A halves
	logic [63:0] sq_c [3];
	logic [39:0] dtsq_c;
	logic [45:0] k1_c;
	logic [53:0] pl_c, ph_c;

	logic        vld_s2;
	logic [63:0] sq_s2 [3];
	vec3_t       pos_s2, vel_s2;
	logic [19:0] dt_s2;
	logic [23:0] dt2_s2;
	logic [30:0] mass_s2;
	logic [53:0] pl_s2, ph_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = mag_s1[i] * mag_s1[i];
		end
		dtsq_c = dt_s1 * dt_s1;
		k1_c   = rhocd_s1[61:16];
		pl_c   = k1_c[22:0] * area_s1;
		ph_c   = k1_c[45:23] * area_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2   <= sq_c;
			pos_s2  <= pos_s1;
			vel_s2  <= vel_s1;
			dt_s2   <= dt_s1;
			dt2_s2  <= dtsq_c[39:16];
			mass_s2 <= mass_s1;
			pl_s2   <= pl_c;
			ph_s2   <= ph_c;
		end
	end

	// ---- stage 3: sum of squares, k2
	logic [76:0] k2full_c;

	logic        vld_s3;
	logic [63:0] sumsq_s3;
	sq_side_t    side_s3;

	assign k2full_c = {ph_s2, 23'b0} + 77'(pl_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sumsq_s3     <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3.pos  <= pos_s2;
			side_s3.vel  <= vel_s2;
			side_s3.dt   <= dt_s2;
			side_s3.dt2  <= dt2_s2;
			side_s3.mass <= mass_s2;
			side_s3.k2   <= k2full_c[76:16];
		end
	end

	// ---- speed
	logic        sq_vld;
	logic [31:0] speed;
	sq_side_t    sq_out;

	psp_isqrt_pipe #(
		.SIDE_W ($bits(sq_side_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.radicand  (sumsq_s3),
		.in_side   (side_s3),
		.out_valid (sq_vld),
		.root      (speed),
		.out_side  (sq_out)
	);

	// ---- stage 4/5: k3 = k2*speed/2^17, saturated
	logic        vld_s4, vld_s5;
	logic [61:0] kh_s4;
	logic [62:0] kl_s4;
	logic [30:0] mass_s4, mass_s5;
	dv_side_t    side_s4, side_s5;
	logic [93:0] k3full_c;
	logic [76:0] k3raw_c;
	logic [62:0] k3_s5;

	assign k3full_c = {kh_s4, 31'b0} + 94'(kl_s4);
	assign k3raw_c  = k3full_c[93:17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kh_s4       <= sq_out.k2[60:31] * speed;
			kl_s4       <= sq_out.k2[30:0] * speed;
			mass_s4     <= sq_out.mass;
			side_s4.pos <= sq_out.pos;
			side_s4.vel <= sq_out.vel;
			side_s4.dt  <= sq_out.dt;
			side_s4.dt2 <= sq_out.dt2;
			k3_s5       <= (k3raw_c > 77'(DRAG_CAP)) ? DRAG_CAP : k3raw_c[62:0];
			mass_s5     <= mass_s4;
			side_s5     <= side_s4;
		end
	end

	// ---- k4 = k3*2^16/mass
	logic        dv_vld;
	logic [62:0] k4;
	dv_side_t    dv_out;

	psp_div_pipe #(
		.SIDE_W ($bits(dv_side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.k3        (k3_s5),
		.mass      (mass_s5),
		.in_side   (side_s5),
		.out_valid (dv_vld),
		.k4        (k4),
		.out_side  (dv_out)
	);

	// ---- stage 6/7/8: drag per lane, acceleration
	vec3_t       mag6_c;
	logic [95:0] dmfull_c [3];
	logic [79:0] dmraw_c  [3];
	logic signed [63:0] drag_c [3];
	logic signed [63:0] asum_c [3];

	logic        vld_s6, vld_s7, vld_s8;
	logic [62:0] hh_s6 [3];
	logic [63:0] ll_s6 [3];
	logic [62:0] dm_s7 [3];
	vec3_t       acc_s8;
	dv_side_t    side_s6, side_s7, side_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag6_c[i]   = dv_out.vel[i][31] ? (~dv_out.vel[i] + 32'd1) : dv_out.vel[i];
			dmfull_c[i] = {hh_s6[i], 32'b0} + 96'(ll_s6[i]);
			dmraw_c[i]  = dmfull_c[i][95:16];
			// drag opposes velocity
			drag_c[i]   = side_s7.vel[i][31] ? $signed({1'b0, dm_s7[i]})
			                                 : -$signed({1'b0, dm_s7[i]});
			asum_c[i]   = 64'($signed(grav_q[i])) + 64'($signed(wind_q[i])) + drag_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hh_s6[i]  <= k4[62:32] * mag6_c[i];
				ll_s6[i]  <= k4[31:0] * mag6_c[i];
				dm_s7[i]  <= (dmraw_c[i] > 80'(DRAG_CAP)) ? DRAG_CAP : dmraw_c[i][62:0];
				acc_s8[i] <= sat_s32_64(asum_c[i]);
			end
			side_s6 <= dv_out;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
		end
	end

	// ---- stage 9: step products
	logic               vld_s9;
	logic signed [52:0] vdt_s9  [3];
	logic signed [52:0] adt_s9  [3];
	logic signed [56:0] adt2_s9 [3];
	vec3_t              pos_s9, vel_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vdt_s9[i]  <= $signed(side_s8.vel[i]) * $signed({1'b0, side_s8.dt});
				adt_s9[i]  <= $signed(acc_s8[i]) * $signed({1'b0, side_s8.dt});
				adt2_s9[i] <= $signed(acc_s8[i]) * $signed({1'b0, side_s8.dt2});
			end
			pos_s9 <= side_s8.pos;
			vel_s9 <= side_s8.vel;
		end
	end

	// ---- result: shifts round toward zero, then saturate
	logic signed [52:0] vdt_b [3];
	logic signed [52:0] adt_b [3];
	logic signed [56:0] adt2_b [3];
	logic signed [41:0] np_c [3];
	logic signed [41:0] nv_c [3];
	vec3_t              np_sat, nv_sat;
	pred_t              res_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vdt_b[i]  = vdt_s9[i] + (vdt_s9[i][52] ? 53'sh0FFFF : 53'sh0);
			adt_b[i]  = adt_s9[i] + (adt_s9[i][52] ? 53'sh0FFFF : 53'sh0);
			adt2_b[i] = adt2_s9[i] + (adt2_s9[i][56] ? 57'sh1FFFF : 57'sh0);
			np_c[i]   = 42'($signed(pos_s9[i])) + 42'($signed(vdt_b[i][52:16]))
			          + 42'($signed(adt2_b[i][56:17]));
			nv_c[i]   = 42'($signed(vel_s9[i])) + 42'($signed(adt_b[i][52:16]));
			np_sat[i] = sat_s32_42(np_c[i]);
			nv_sat[i] = sat_s32_42(nv_c[i]);
		end
		res_c.new_pos_x = np_sat[0];
		res_c.new_pos_y = np_sat[1];
		res_c.new_pos_z = np_sat[2];
		res_c.new_vel_x = nv_sat[0];
		res_c.new_vel_y = nv_sat[1];
		res_c.new_vel_z = nv_sat[2];
	end

	// ---- output register with skid word
	logic take;
	assign take = out_valid_q && !pred_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (vld_s9) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (vld_s9) begin
			if (!out_valid_q || take) begin
				out_q <= res_c;
			end else begin
				skid_q <= res_c;
			end
		end
	end

	assign pred_valid = out_valid_q;
	assign pred       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with no output word");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && pred_stall))
		else $error("skid filled while output was free");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !pred_stall |=> !skid_valid_q && out_valid_q)
		else $error("skid word not moved on when output taken");

endmodule

>>> tb/testbench.sv
module testbench;
	import psp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;	// no register behind it
	localparam logic [63:0] MAG_CAP = 64'h4000_0000_0000_0000;
	localparam int PIPE_WAIT  = 120;
	localparam int QUIET_MAX  = 20000;
	localparam int HOLD_LEN   = 400;
	localparam int PHASE_LEN  = 275;
	localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S_MIN = 32'h8000_0000;

	typedef struct {
		body_t b;
		bit    known;
		pred_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic body_valid;
	logic body_stall;
	body_t body;
	logic pred_valid;
	logic pred_stall;
	pred_t pred;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic signed [31:0] grav_m[3];
	logic signed [31:0] wind_m[3];
	logic [30:0] dens_m;

	pred_t pending_preds[$];
	row_t dir_rows[11];
	int errors;
	int bodies_sent;
	int preds_seen;
	int quiet = 0;
	int hold_cnt;
	bit hold_req;
	bit calm;

	projectile_state_predict_drag dut (
		.clk(clk), .arst_n(arst_n),
		.body_valid(body_valid), .body_stall(body_stall), .body(body),
		.pred_valid(pred_valid), .pred_stall(pred_stall), .pred(pred),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] mul_shift_cap(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		if (p > {64'd0, MAG_CAP})
			return MAG_CAP;
		return p[63:0];
	endfunction

	function automatic logic [63:0] int_root(logic [63:0] n);
		logic [63:0] res, probe, nn;
		nn = n;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > nn)
			probe = probe >> 2;
		while (probe != 0) begin
			if (nn >= res + probe) begin
				nn = nn - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic longint shift_toward_zero(longint x, int sh);
		longint m;
		m = (x < 0 ? -x : x) >>> sh;
		return x < 0 ? -m : m;
	endfunction

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// one Euler-style step with quadratic drag, all fixed point
	function automatic pred_t step_body(body_t b);
		longint p[3], v[3], acc[3], drag, dtl, dt2l, np, nv;
		logic [63:0] m, sumsq, speed, k1, k2, k3, k4, q, r, mass, dt;
		logic [31:0] po[3], vo[3];
		p[0] = b.pos_x; p[1] = b.pos_y; p[2] = b.pos_z;
		v[0] = b.vel_x; v[1] = b.vel_y; v[2] = b.vel_z;
		dt = b.step_time;
		mass = (b.body_mass == 0) ? 64'd65536 : b.body_mass;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			m = v[i] < 0 ? -v[i] : v[i];
			sumsq += m * m;
		end
		speed = int_root(sumsq);
		k4 = 0;
		if (speed != 0) begin
			k1 = mul_shift_cap(dens_m, b.drag_coeff, 16);
			k2 = mul_shift_cap(k1, b.cross_area, 16);
			k3 = mul_shift_cap(k2, speed, 17);
			q = k3 / mass;
			r = k3 % mass;
			if (q >= (64'd1 << 46)) begin
				k4 = MAG_CAP;
			end else begin
				k4 = (q << 16) + ((r << 16) / mass);
				if (k4 > MAG_CAP)
					k4 = MAG_CAP;
			end
		end
		for (int i = 0; i < 3; i++) begin
			drag = 0;
			if (k4 != 0) begin
				m = v[i] < 0 ? -v[i] : v[i];
				drag = mul_shift_cap(k4, m, 16);
				if (v[i] >= 0)
					drag = -drag;
			end
			acc[i] = clip32(longint'(grav_m[i]) + longint'(wind_m[i]) + drag);
		end
		dtl = dt;
		dt2l = (dt * dt) >> 16;
		for (int i = 0; i < 3; i++) begin
			np = p[i] + shift_toward_zero(v[i] * dtl, 16)
				+ shift_toward_zero(acc[i] * dt2l, 17);
			nv = v[i] + shift_toward_zero(acc[i] * dtl, 16);
			po[i] = 32'(clip32(np));
			vo[i] = 32'(clip32(nv));
		end
		return '{po[0], po[1], po[2], vo[0], vo[1], vo[2]};
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	// receive side, with random stalls and one long hold-off
	initial begin
		pred_t w;
		pred_stall <= 1'b0;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (pred_valid && !pred_stall) begin
				preds_seen++;
				if (pending_preds.size() == 0) begin
					$error("pred word with nothing outstanding");
					errors++;
				end else begin
					w = pending_preds.pop_front();
					check_field("new_pos_x", w.new_pos_x, pred.new_pos_x);
					check_field("new_pos_y", w.new_pos_y, pred.new_pos_y);
					check_field("new_pos_z", w.new_pos_z, pred.new_pos_z);
					check_field("new_vel_x", w.new_vel_x, pred.new_vel_x);
					check_field("new_vel_y", w.new_vel_y, pred.new_vel_y);
					check_field("new_vel_z", w.new_vel_z, pred.new_vel_z);
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_LEN;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pred_stall <= 1'b1;
			end else begin
				pred_stall <= !calm && ($urandom_range(99) < 33);
			end
		end
	end

	always @(posedge clk) begin
		if ((body_valid && !body_stall) || (pred_valid && !pred_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > QUIET_MAX) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_body(body_t b, bit known, pred_t want);
		body <= b;
		body_valid <= 1'b1;
		do @(posedge clk); while (body_stall);
		pending_preds.push_back(known ? want : step_body(b));
		bodies_sent++;
		if (!calm && $urandom_range(99) < 33) begin
			body_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic drain_pipe();
		body_valid <= 1'b0;
		while (pending_preds.size() != 0)
			@(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx <= CFG_GRAV_Z)
			grav_m[idx[1:0]] = val;
		else if (idx <= CFG_WIND_Z)
			wind_m[2'(idx - CFG_WIND_X)] = val;
		else if (idx == CFG_DENSITY)
			dens_m = val[30:0];
	endtask

	task automatic program_regs(logic [31:0] g[3], logic [31:0] wv[3], logic [30:0] rho);
		cfg_write(CFG_GRAV_X, g[0]);
		cfg_write(CFG_GRAV_Y, g[1]);
		cfg_write(CFG_GRAV_Z, g[2]);
		cfg_write(CFG_WIND_X, wv[0]);
		cfg_write(CFG_WIND_Y, wv[1]);
		cfg_write(CFG_WIND_Z, wv[2]);
		cfg_write(CFG_DENSITY, {1'b0, rho});
		cfg_write(CFG_SPARE, $urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic body_t rand_body(int kind);
		body_t b;
		b.pos_x = $urandom(); b.pos_y = $urandom(); b.pos_z = $urandom();
		b.vel_x = $urandom(); b.vel_y = $urandom(); b.vel_z = $urandom();
		b.step_time = 20'($urandom());
		b.body_mass = 31'($urandom());
		b.drag_coeff = 31'($urandom());
		b.cross_area = 31'($urandom());
		if (kind >= 1) begin
			// plausible flight: speeds to about 1000, light bodies, short steps
			b.vel_x = int'($urandom_range(0, 1 << 27)) - (1 << 26);
			b.vel_y = int'($urandom_range(0, 1 << 27)) - (1 << 26);
			b.vel_z = int'($urandom_range(0, 1 << 27)) - (1 << 26);
			b.step_time = 20'($urandom_range(0, 8192));
			b.body_mass = 31'($urandom_range(0, 100 << 16));
			b.drag_coeff = 31'($urandom_range(0, 2 << 16));
			b.cross_area = 31'($urandom_range(0, 1 << 16));
		end
		if (kind == 2) begin
			b.vel_x = 0; b.vel_y = 0; b.vel_z = 0;
		end
		if (kind == 3)
			b.body_mass = 0;
		return b;
	endfunction

	initial begin
		logic [31:0] g[3], wv[3];
		logic [30:0] rho;
		pred_t none;
		body_t b;
		int kind;
		none = '0;
		errors = 0; bodies_sent = 0; preds_seen = 0;
		hold_req = 1'b0; calm = 1'b0;
		arst_n <= 1'b0;
		body_valid <= 1'b0;
		body <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_GRAV_X;
		cfg_data <= '0;
		grav_m[0] = GRAV_X_RST; grav_m[1] = GRAV_Y_RST; grav_m[2] = GRAV_Z_RST;
		wind_m[0] = WIND_RST; wind_m[1] = WIND_RST; wind_m[2] = WIND_RST;
		dens_m = DENSITY_RST;

		// zero step returns the input untouched
		dir_rows[0] = '{body_t'('0), 1'b1, pred_t'('0)};
		dir_rows[1] = '{body_t'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 20'd0,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF}, 1'b1,
			pred_t'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}};
		dir_rows[2] = '{body_t'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 20'd0,
			31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF}, 1'b1,
			pred_t'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}};
		// at rest, one second under reset gravity, massless body
		dir_rows[3] = '{body_t'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 20'd65536,
			31'd0, 31'd65536, 31'd65536}, 1'b1,
			pred_t'{32'd0, -32'sd321454, 32'd0, 32'd0, -32'sd642908, 32'd0}};
		dir_rows[4] = '{body_t'{S_MAX, S_MIN, 32'd0, S_MAX, S_MAX, S_MAX, 20'hFFFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF}, 1'b0, none};
		dir_rows[5] = '{body_t'{32'd0, 32'd0, 32'd0, S_MIN, S_MIN, S_MIN, 20'hFFFFF,
			31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF}, 1'b0, none};
		dir_rows[6] = '{body_t'{32'd0, 32'd655360, 32'd0, 32'd655360, 32'd1310720,
			-32'sd327680, 20'd1092, 31'd65536, 31'd30802, 31'd655}, 1'b0, none};
		dir_rows[7] = '{rand_body(0), 1'b0, none};
		dir_rows[8] = '{body_t'{32'd0, 32'd0, 32'd0, 32'd65536, -32'sd65536, 32'd1,
			20'd4096, 31'd1, 31'd65536, 31'd65536}, 1'b0, none};
		dir_rows[9] = '{body_t'{S_MAX, S_MIN, 32'd0, 32'd0, 32'd0, 32'd0, 20'hFFFFF,
			31'd65536, 31'd0, 31'd0}, 1'b0, none};
		dir_rows[10] = '{body_t'{32'd0, 32'd0, 32'd0, -32'sd3276800, 32'd0, 32'd0,
			20'd65536, 31'd131072, 31'd65536, 31'd65536}, 1'b0, none};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_body(dir_rows[i].b, dir_rows[i].known, dir_rows[i].want);

		for (int ph = 0; ph < 6; ph++) begin
			drain_pipe();
			case (ph)
				1: begin
					g = '{S_MAX, S_MAX, S_MAX}; wv = '{S_MAX, S_MAX, S_MAX};
					rho = 31'h7FFF_FFFF;
				end
				2: begin
					g = '{S_MIN, S_MIN, S_MIN}; wv = '{S_MIN, S_MIN, S_MIN};
					rho = 31'd0;
				end
				3: begin
					g = '{32'd0, 32'd0, 32'd0}; wv = '{32'd0, 32'd0, 32'd0};
					rho = DENSITY_RST;
				end
				4: begin
					g = '{32'd0, -32'sd642908, 32'd0};
					wv = '{$urandom_range(0, 131072) - 65536, 32'd0,
						$urandom_range(0, 131072) - 65536};
					rho = 31'($urandom_range(0, 1 << 17));
				end
				5: begin
					g = '{$urandom(), $urandom(), $urandom()};
					wv = '{$urandom(), $urandom(), $urandom()};
					rho = 31'($urandom());
				end
				default: ;
			endcase
			if (ph != 0)
				program_regs(g, wv, rho);
			calm = (ph == 3);
			if (ph == 4) begin
				calm = 1'b1;
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph == 4 && n == 150)
					calm = 1'b0;
				kind = $urandom_range(0, 9);
				kind = (kind < 2) ? 0 : (kind < 7) ? 1 : (kind == 7) ? 2 : 3;
				b = rand_body(kind);
				send_body(b, 1'b0, none);
			end
			calm = 1'b0;
		end

		drain_pipe();
		$display("run: %0d bodies, %0d predictions checked over 6 gravity/wind/density settings",
			bodies_sent, preds_seen);
		$display("includes extremes, zero speed, zero mass, drag saturation, long output hold-off");
		if (errors == 0 && pending_preds.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/psp_pkg.sv
hw/rtl/psp_isqrt_pipe.sv
hw/rtl/psp_div_pipe.sv
hw/rtl/projectile_state_predict_drag.sv
tb/testbench.sv
